// ===== hw/rtl/brsc_pkg.sv =====
// ----------------------------------------------------------------------------
// brsc_pkg: shared types and constants for the banker's request checker
// Sizes, field widths, op and status codes, sequencer states and the
// structs that pass between the sequencer, the matrix store and the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

	// built sizes
	localparam int MAX_PROCS = 8;
	localparam int MAX_RES   = 8;
	localparam int UNIT_BITS = 16;

	localparam int PIDX_BITS = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RIDX_BITS = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int PCNT_BITS = $clog2(MAX_PROCS + 1);
	localparam int RCNT_BITS = $clog2(MAX_RES + 1);
	// work can grow to available plus every allocation of a column
	localparam int WORK_BITS = UNIT_BITS + $clog2(MAX_PROCS + 1);
	localparam int MAT_DEPTH = MAX_PROCS * MAX_RES;
	localparam int MAT_ABITS = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

	// fixed field widths
	localparam int CFG_BITS     = 4;
	localparam int OP_BITS      = 2;
	localparam int PID_BITS     = 4;
	localparam int RID_BITS     = 3;
	localparam int VAL_BITS     = 16;
	localparam int STATUS_BITS  = 2;
	localparam int IN_TDATA_BITS  = 32;
	localparam int OUT_TDATA_BITS = 8;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	localparam int CFG_RESET = 8;

	typedef logic [UNIT_BITS-1:0] unit_t;
	typedef logic [WORK_BITS-1:0] work_t;
	typedef logic [PCNT_BITS-1:0] pcnt_t;
	typedef logic [RCNT_BITS-1:0] rcnt_t;
	typedef logic [MAT_ABITS-1:0] mat_addr_t;
	typedef logic [CFG_BITS-1:0]  cfg_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_AVAIL = 2'd0,
		OP_MAX   = 2'd1,
		OP_ALLOC = 2'd2,
		OP_REQ   = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_UNSAFE       = 2'd0,
		ST_REFUSED      = 2'd1,
		ST_GRANT_SAFE   = 2'd2,
		ST_GRANT_UNSAFE = 2'd3
	} status_t;

	typedef enum logic {
		REG_NUM_PROCS = 1'b0,
		REG_NUM_RES   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		U_ADD = 1'b0,
		U_SUB = 1'b1
	} unit_op_t;

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_INIT     = 15'h0002,
		S_PSEL     = 15'h0004,
		S_FIT_RD   = 15'h0008,
		S_FIT_CMP  = 15'h0010,
		S_ADD_RD   = 15'h0020,
		S_ADD_EXE  = 15'h0040,
		S_CHK      = 15'h0080,
		S_REQ_RD   = 15'h0100,
		S_REQ_NEED = 15'h0200,
		S_REQ_AVL  = 15'h0400,
		S_APP_RD   = 15'h0800,
		S_APP_ADD  = 15'h1000,
		S_APP_SUB  = 15'h2000,
		S_RES      = 15'h4000
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [PID_BITS-1:0] process_index;
		logic [RID_BITS-1:0] resource_index;
		logic [VAL_BITS-1:0] value;
		logic                last;
	} item_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} res_t;

	typedef struct packed {
		logic      we_max;
		logic      we_alloc;
		mat_addr_t addr;
		unit_t     data;
	} mat_wr_t;

	typedef struct packed {
		unit_op_t op;
		logic     need_on_a;
		logic     need_on_b;
		work_t    a;
		work_t    b;
		unit_t    max_v;
		unit_t    alloc_v;
	} unit_in_t;

	typedef struct packed {
		work_t y;
		logic  borrow;
	} unit_out_t;

	function automatic mat_addr_t mat_addr(logic [PIDX_BITS-1:0] p, logic [RIDX_BITS-1:0] r);
		return MAT_ABITS'(int'(p) * MAX_RES + int'(r));
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brsc_unit.sv =====
// ----------------------------------------------------------------------------
// brsc_unit: shared arithmetic unit
// Clamped need (max minus allocation) in front of one add/subtract with
// borrow; need can stand in for either operand.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_unit (
	input  brsc_pkg::unit_in_t  u_in,
	output brsc_pkg::unit_out_t u_out
);
	import brsc_pkg::*;

	unit_t need;
	work_t opa;
	work_t opb;
	logic [WORK_BITS:0] diff;

	always_comb begin
		need = (u_in.max_v > u_in.alloc_v) ? (u_in.max_v - u_in.alloc_v) : '0;
		opa  = u_in.need_on_a ? WORK_BITS'(need) : u_in.a;
		opb  = u_in.need_on_b ? WORK_BITS'(need) : u_in.b;
		diff = {1'b0, opa} - {1'b0, opb};
		unique case (u_in.op)
			U_ADD: begin
				u_out.y      = opa + opb;
				u_out.borrow = 1'b0;
			end
			U_SUB: begin
				u_out.y      = diff[WORK_BITS-1:0];
				u_out.borrow = diff[WORK_BITS];
			end
			default: begin
				u_out.y      = '0;
				u_out.borrow = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/brsc_matrix.sv =====
// ----------------------------------------------------------------------------
// brsc_matrix: max-claim and allocation matrix store
// Two memories sharing one write address and one read address, with
// registered read data; per-entry valid bits make unwritten entries read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_matrix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brsc_pkg::mat_wr_t    wr,
	input  brsc_pkg::mat_addr_t  raddr,
	output brsc_pkg::unit_t      rd_max,
	output brsc_pkg::unit_t      rd_alloc
);
	import brsc_pkg::*;

	unit_t max_mem   [MAT_DEPTH];
	unit_t alloc_mem [MAT_DEPTH];
	logic [MAT_DEPTH-1:0] max_vld_q;
	logic [MAT_DEPTH-1:0] alloc_vld_q;
	unit_t max_rd_q;
	unit_t alloc_rd_q;
	logic  max_rv_q;
	logic  alloc_rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vld_q   <= '0;
			alloc_vld_q <= '0;
			max_rv_q    <= 1'b0;
			alloc_rv_q  <= 1'b0;
		end else begin
			if (wr.we_max)
				max_vld_q[wr.addr] <= 1'b1;
			if (wr.we_alloc)
				alloc_vld_q[wr.addr] <= 1'b1;
			max_rv_q   <= max_vld_q[raddr];
			alloc_rv_q <= alloc_vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we_max)
			max_mem[wr.addr] <= wr.data;
		if (wr.we_alloc)
			alloc_mem[wr.addr] <= wr.data;
		max_rd_q   <= max_mem[raddr];
		alloc_rd_q <= alloc_mem[raddr];
	end

	assign rd_max   = max_rv_q ? max_rd_q : '0;
	assign rd_alloc = alloc_rv_q ? alloc_rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/brsc_seq.sv =====
// ----------------------------------------------------------------------------
// brsc_seq: load handling and evaluation sequencer
// Holds the available, request and work vectors and the finish flags, and
// steps the shared unit through safety sweeps, request check and apply.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brsc_pkg::pcnt_t      np,
	input  brsc_pkg::rcnt_t      nr,
	input  logic                 item_valid,
	input  brsc_pkg::item_t      item,
	output logic                 ready,
	input  logic                 res_free,
	output brsc_pkg::res_t       res,
	output brsc_pkg::mat_wr_t    mat_wr,
	output brsc_pkg::mat_addr_t  mat_raddr,
	input  brsc_pkg::unit_t      rd_max,
	input  brsc_pkg::unit_t      rd_alloc,
	output brsc_pkg::unit_in_t   u_in,
	input  brsc_pkg::unit_out_t  u_out
);
	import brsc_pkg::*;

	state_t  state_q;
	logic    phase_q;
	logic    progress_q;
	pcnt_t   p_q;
	rcnt_t   r_q;
	logic [PID_BITS-1:0] pid_q;
	status_t status_q;
	logic [MAX_PROCS-1:0] finish_q;
	work_t   work_q  [MAX_RES];
	unit_t   avail_q [MAX_RES];
	unit_t   req_q   [MAX_RES];

	logic accept;
	logic rid_ok;
	logic pid_ok;
	logic p_end;
	logic r_end;
	logic eval_pid_ok;
	logic all_done;
	logic req_row;
	logic [MAX_PROCS-1:0] done_v;
	logic [RIDX_BITS-1:0] r_idx;
	logic [RIDX_BITS-1:0] ld_ridx;
	logic [PIDX_BITS-1:0] ld_pidx;
	logic [PIDX_BITS-1:0] p_idx;
	logic [PIDX_BITS-1:0] e_pidx;
	unit_t ld_val;

	assign ready       = (state_q == S_IDLE);
	assign accept      = item_valid && ready;
	assign rid_ok      = int'(item.resource_index) < int'(nr);
	assign pid_ok      = int'(item.process_index) < int'(np);
	assign eval_pid_ok = int'(pid_q) < int'(np);
	assign p_end       = p_q >= np;
	assign r_end       = r_q >= nr;
	assign r_idx       = r_q[RIDX_BITS-1:0];
	assign p_idx       = p_q[PIDX_BITS-1:0];
	assign e_pidx      = PIDX_BITS'(pid_q);
	assign ld_ridx     = RIDX_BITS'(item.resource_index);
	assign ld_pidx     = PIDX_BITS'(item.process_index);
	assign ld_val      = UNIT_BITS'(item.value);

	assign res.valid  = (state_q == S_RES);
	assign res.status = status_q;

	// processes beyond the count in use count as finished
	always_comb begin
		for (int i = 0; i < MAX_PROCS; i++)
			done_v[i] = finish_q[i] || (i >= int'(np));
		all_done = &done_v;
	end

	// request check and apply walk the requesting row, sweeps walk p
	assign req_row   = (state_q == S_REQ_RD) || (state_q == S_APP_RD);
	assign mat_raddr = mat_addr(req_row ? e_pidx : p_idx, r_idx);

	always_comb begin
		mat_wr = '0;
		if (accept && rid_ok && pid_ok) begin
			mat_wr.addr = mat_addr(ld_pidx, ld_ridx);
			mat_wr.data = ld_val;
			mat_wr.we_max   = (item.op == OP_MAX);
			mat_wr.we_alloc = (item.op == OP_ALLOC);
		end else if (state_q == S_APP_ADD) begin
			mat_wr.we_alloc = 1'b1;
			mat_wr.addr     = mat_addr(e_pidx, r_idx);
			mat_wr.data     = u_out.y[UNIT_BITS-1:0];
		end
	end

	always_comb begin
		u_in         = '0;
		u_in.op      = U_ADD;
		u_in.max_v   = rd_max;
		u_in.alloc_v = rd_alloc;
		unique case (state_q)
			S_FIT_CMP: begin
				u_in.op        = U_SUB;
				u_in.a         = work_q[r_idx];
				u_in.need_on_b = 1'b1;
			end
			S_ADD_EXE: begin
				u_in.a = work_q[r_idx];
				u_in.b = WORK_BITS'(rd_alloc);
			end
			S_REQ_NEED: begin
				u_in.op        = U_SUB;
				u_in.need_on_a = 1'b1;
				u_in.b         = WORK_BITS'(req_q[r_idx]);
			end
			S_REQ_AVL, S_APP_SUB: begin
				u_in.op = U_SUB;
				u_in.a  = WORK_BITS'(avail_q[r_idx]);
				u_in.b  = WORK_BITS'(req_q[r_idx]);
			end
			S_APP_ADD: begin
				u_in.a = WORK_BITS'(rd_alloc);
				u_in.b = WORK_BITS'(req_q[r_idx]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= 1'b0;
			progress_q <= 1'b0;
			p_q        <= '0;
			r_q        <= '0;
			pid_q      <= '0;
			status_q   <= ST_UNSAFE;
			finish_q   <= '0;
			for (int i = 0; i < MAX_RES; i++) begin
				work_q[i]  <= '0;
				avail_q[i] <= '0;
				req_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.op)
							OP_AVAIL: begin
								if (rid_ok)
									avail_q[ld_ridx] <= ld_val;
							end
							OP_REQ: begin
								if (rid_ok)
									req_q[ld_ridx] <= ld_val;
								if (item.last) begin
									pid_q   <= item.process_index;
									phase_q <= 1'b0;
									state_q <= S_INIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_INIT: begin
					for (int i = 0; i < MAX_RES; i++)
						work_q[i] <= WORK_BITS'(avail_q[i]);
					finish_q   <= '0;
					progress_q <= 1'b0;
					p_q        <= '0;
					state_q    <= S_PSEL;
				end
				S_PSEL: begin
					if (p_end) begin
						if (progress_q) begin
							p_q        <= '0;
							progress_q <= 1'b0;
						end else begin
							state_q <= S_CHK;
						end
					end else if (finish_q[p_idx]) begin
						p_q <= p_q + PCNT_BITS'(1);
					end else begin
						r_q     <= '0;
						state_q <= S_FIT_RD;
					end
				end
				S_FIT_RD: begin
					if (r_end) begin
						r_q     <= '0;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_FIT_CMP;
					end
				end
				S_FIT_CMP: begin
					// borrow: need exceeds work, this process cannot run yet
					if (u_out.borrow) begin
						p_q     <= p_q + PCNT_BITS'(1);
						state_q <= S_PSEL;
					end else begin
						r_q     <= r_q + RCNT_BITS'(1);
						state_q <= S_FIT_RD;
					end
				end
				S_ADD_RD: begin
					if (r_end) begin
						finish_q[p_idx] <= 1'b1;
						progress_q      <= 1'b1;
						p_q             <= p_q + PCNT_BITS'(1);
						state_q         <= S_PSEL;
					end else begin
						state_q <= S_ADD_EXE;
					end
				end
				S_ADD_EXE: begin
					work_q[r_idx] <= u_out.y;
					r_q           <= r_q + RCNT_BITS'(1);
					state_q       <= S_ADD_RD;
				end
				S_CHK: begin
					if (phase_q) begin
						status_q <= all_done ? ST_GRANT_SAFE : ST_GRANT_UNSAFE;
						state_q  <= S_RES;
					end else if (!all_done) begin
						status_q <= ST_UNSAFE;
						state_q  <= S_RES;
					end else if (!eval_pid_ok) begin
						status_q <= ST_REFUSED;
						state_q  <= S_RES;
					end else begin
						r_q     <= '0;
						state_q <= S_REQ_RD;
					end
				end
				S_REQ_RD: begin
					if (r_end) begin
						r_q     <= '0;
						state_q <= S_APP_RD;
					end else begin
						state_q <= S_REQ_NEED;
					end
				end
				S_REQ_NEED: begin
					if (u_out.borrow) begin
						status_q <= ST_REFUSED;
						state_q  <= S_RES;
					end else begin
						state_q <= S_REQ_AVL;
					end
				end
				S_REQ_AVL: begin
					if (u_out.borrow) begin
						status_q <= ST_REFUSED;
						state_q  <= S_RES;
					end else begin
						r_q     <= r_q + RCNT_BITS'(1);
						state_q <= S_REQ_RD;
					end
				end
				S_APP_RD: begin
					if (r_end) begin
						phase_q <= 1'b1;
						state_q <= S_INIT;
					end else begin
						state_q <= S_APP_ADD;
					end
				end
				S_APP_ADD: begin
					state_q <= S_APP_SUB;
				end
				S_APP_SUB: begin
					avail_q[r_idx] <= u_out.y[UNIT_BITS-1:0];
					r_q            <= r_q + RCNT_BITS'(1);
					state_q        <= S_APP_RD;
				end
				S_RES: begin
					if (res_free) begin
						for (int i = 0; i < MAX_RES; i++)
							req_q[i] <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bankers_request_safety_check.sv =====
// ----------------------------------------------------------------------------
// bankers_request_safety_check: banker's algorithm request engine
// Stream input of load and request words, one status word per evaluated
// request, APB registers for the process and resource counts in use.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake                 payload
//   s_*       in    s_tvalid / s_tready        s_tdata: op, process_index,
//                                              resource_index, value; s_tlast
//   m_*       out   m_tvalid / m_tready        m_tdata: status
//   apb       in    psel, penable, pwrite      paddr, pwdata -> prdata
//
// load words and request words without tlast are taken back to back while idle
// a request word with tlast starts an evaluation; s_tready stays low until
// it ends: a safety check sweeps the processes (at most np + 1 sweeps),
// fit-testing each unfinished one per resource and retiring one that fits by
// adding its allocation to work; request check tests need and available per
// resource, apply moves the request from available into the allocation, a
// granted request runs a second check, and the status goes to the output
// register (later while it is full); one matrix read port and the single
// add/subtract unit serve every step; the status sits in an output register,
// so loads are taken while it waits; reset clears the matrices (via valid
// bits) and vectors, and sets both counts to 8
`default_nettype none

module bankers_request_safety_check (
	input  logic                                clk,
	input  logic                                arst_n,
	// stream input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [brsc_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [1:0] op, [5:2] process_index,
	                                                       // [8:6] resource_index,
	                                                       // [24:9] value, rest 0
	input  logic                                s_tlast,
	// stream output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [brsc_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [1:0] status, rest 0
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [brsc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [brsc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [brsc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready
);
	import brsc_pkg::*;

	// config registers, stored as written
	cfg_t  num_procs_q;
	cfg_t  num_res_q;
	pcnt_t np;
	rcnt_t nr;
	logic  cfg_wr;

	// output word register
	logic    out_valid_q;
	status_t out_status_q;
	logic    res_free;

	item_t     item;
	res_t      res;
	mat_wr_t   mat_wr;
	mat_addr_t mat_raddr;
	unit_t     rd_max;
	unit_t     rd_alloc;
	unit_in_t  u_in;
	unit_out_t u_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q <= CFG_BITS'(CFG_RESET);
			num_res_q   <= CFG_BITS'(CFG_RESET);
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(paddr[2]))
				REG_NUM_PROCS: num_procs_q <= pwdata[CFG_BITS-1:0];
				REG_NUM_RES:   num_res_q   <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg_t'(paddr[2]))
			REG_NUM_PROCS: prdata = APB_DATA_BITS'(num_procs_q);
			REG_NUM_RES:   prdata = APB_DATA_BITS'(num_res_q);
			default:       prdata = '0;
		endcase
	end

	// counts above the built size saturate
	assign np = (int'(num_procs_q) > MAX_PROCS) ? PCNT_BITS'(MAX_PROCS)
	                                            : PCNT_BITS'(num_procs_q);
	assign nr = (int'(num_res_q) > MAX_RES) ? RCNT_BITS'(MAX_RES)
	                                        : RCNT_BITS'(num_res_q);

	// unpack the input word
	assign item.op             = op_t'(s_tdata[1:0]);
	assign item.process_index  = s_tdata[5:2];
	assign item.resource_index = s_tdata[8:6];
	assign item.value          = s_tdata[24:9];
	assign item.last           = s_tlast;

	// a finished status moves out once the output register is free
	assign res_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_free)
			out_status_q <= res.status;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_BITS'(out_status_q);

	brsc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.np         (np),
		.nr         (nr),
		.item_valid (s_tvalid),
		.item       (item),
		.ready      (s_tready),
		.res_free   (res_free),
		.res        (res),
		.mat_wr     (mat_wr),
		.mat_raddr  (mat_raddr),
		.rd_max     (rd_max),
		.rd_alloc   (rd_alloc),
		.u_in       (u_in),
		.u_out      (u_out)
	);

	brsc_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (mat_wr),
		.raddr    (mat_raddr),
		.rd_max   (rd_max),
		.rd_alloc (rd_alloc)
	);

	brsc_unit u_unit (
		.u_in  (u_in),
		.u_out (u_out)
	);

endmodule

`default_nettype wire

// ===== tb/bankers_request_safety_check_test.sv =====
// ----------------------------------------------------------------------------
// bankers_request_safety_check_test: self-checking bench for the banker's engine
// Drives load and request words through the stream port, changes the process
// and resource counts over APB between phases, predicts each status word
// with a private ledger of the matrices (or takes the typed status of a pinned row) and compares results in order.
// ----------------------------------------------------------------------------

module bankers_request_safety_check_test;

	import brsc_pkg::*;

	// one directed stimulus row: the word, and a status typed in where it is obvious
	typedef struct {
		item_t   w;
		bit      pinned;
		status_t want;
	} probe_t;

	// one register setting and how many effective words to spend on it
	typedef struct {
		cfg_t procs;
		cfg_t res;
		int   words;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [1:0] op, [5:2] process_index, [8:6] resource_index,
	                        // [24:9] value, rest 0
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [1:0] status, rest 0
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// ledger: the bench's own copy of the engine state
	unit_t       ledger_avail [MAX_RES];
	unit_t       ledger_max   [MAX_PROCS][MAX_RES];
	unit_t       ledger_alloc [MAX_PROCS][MAX_RES];
	unit_t       ledger_req   [MAX_RES];
	int unsigned procs_in_use = MAX_PROCS;
	int unsigned res_in_use   = MAX_RES;

	// status words still owed by the engine, oldest first
	status_t     pending_status [$];

	bit          calm;           // no idling on either side
	bit          pinned_on;      // next evaluating word carries a typed status
	status_t     pinned_status;
	int          taken_words;    // accepted words that were not simply ignored
	int          all_words;
	int          failures;
	int          settings_seen;
	int          status_tally [4];

	// directed part at the reset counts (8 processes, 8 resources)
	probe_t probe_rows [25] = '{
		// all-zero state: a zero request fits and stays safe
		'{'{OP_REQ,   4'd0,  3'd0, 16'h0000, 1'b1}, 1'b1, ST_GRANT_SAFE},
		// bad process index with a full-scale element
		'{'{OP_REQ,   4'd15, 3'd7, 16'hffff, 1'b1}, 1'b1, ST_REFUSED},
		// one unit more than a zero need
		'{'{OP_REQ,   4'd3,  3'd2, 16'h0001, 1'b1}, 1'b1, ST_REFUSED},
		'{'{OP_AVAIL, 4'd0,  3'd7, 16'hffff, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_MAX,   4'd7,  3'd7, 16'hffff, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_AVAIL, 4'd0,  3'd7, 16'hfffe, 1'b0}, 1'b0, ST_UNSAFE},
		// last process needs one unit more than exists: current state unsafe
		'{'{OP_REQ,   4'd0,  3'd0, 16'h0000, 1'b1}, 1'b1, ST_UNSAFE},
		// load with tlast set, must not evaluate
		'{'{OP_ALLOC, 4'd7,  3'd7, 16'hffff, 1'b1}, 1'b0, ST_UNSAFE},
		// process row out of range, dropped
		'{'{OP_MAX,   4'd12, 3'd0, 16'h0064, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_AVAIL, 4'd0,  3'd0, 16'h0004, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_MAX,   4'd0,  3'd0, 16'h0004, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_ALLOC, 4'd0,  3'd0, 16'h0001, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_MAX,   4'd1,  3'd0, 16'h0006, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_ALLOC, 4'd1,  3'd0, 16'h0001, 1'b0}, 1'b0, ST_UNSAFE},
		// fits, but leaves neither process able to finish
		'{'{OP_REQ,   4'd1,  3'd0, 16'h0002, 1'b1}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd1,  3'd3, 16'h0000, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd0,  3'd1, 16'h0000, 1'b1}, 1'b0, ST_UNSAFE},
		'{'{OP_AVAIL, 4'd0,  3'd0, 16'hffff, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd0,  3'd1, 16'h0000, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd0,  3'd0, 16'h0003, 1'b1}, 1'b0, ST_UNSAFE},
		'{'{OP_AVAIL, 4'd0,  3'd0, 16'h0002, 1'b0}, 1'b0, ST_UNSAFE},
		'{'{OP_ALLOC, 4'd1,  3'd0, 16'h0000, 1'b0}, 1'b0, ST_UNSAFE},
		// within need, beyond available
		'{'{OP_REQ,   4'd1,  3'd0, 16'h0005, 1'b1}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd2,  3'd0, 16'h0001, 1'b1}, 1'b0, ST_UNSAFE},
		'{'{OP_REQ,   4'd9,  3'd5, 16'haaaa, 1'b1}, 1'b0, ST_UNSAFE}
	};

	// register settings: extremes, saturation, mostly small sizes; last one runs calm
	phase_t phase_plan [13] = '{
		'{4'd8,  4'd8,  170},
		'{4'd0,  4'd3,   25},
		'{4'd2,  4'd0,   25},
		'{4'd15, 4'd15, 150},
		'{4'd1,  4'd1,   50},
		'{4'd3,  4'd2,   95},
		'{4'd2,  4'd4,   95},
		'{4'd4,  4'd3,   95},
		'{4'd5,  4'd5,   75},
		'{4'd3,  4'd8,   60},
		'{4'd0,  4'd0,   15},
		'{4'd8,  4'd1,   45},
		'{4'd3,  4'd3,   70}
	};

	bankers_request_safety_check i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 12 time unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// ledger: prediction of the engine
	// ------------------------------------------------------------------------

	// remaining claim, never below zero
	function automatic unit_t ledger_need(input int unsigned p, input int unsigned r);
		return (ledger_max[p][r] > ledger_alloc[p][r]) ?
			unit_t'(ledger_max[p][r] - ledger_alloc[p][r]) : '0;
	endfunction

	// sweep the processes until none can finish any more
	function automatic bit ledger_safe();
		work_t       work [MAX_RES];
		bit          done [MAX_PROCS];
		bit          moved;
		bit          fits;
		int unsigned p;
		int unsigned r;
		for (r = 0; r < MAX_RES; r++)
			work[r] = work_t'(ledger_avail[r]);
		for (p = 0; p < MAX_PROCS; p++)
			done[p] = 1'b0;
		moved = 1'b1;
		while (moved) begin
			moved = 1'b0;
			for (p = 0; p < procs_in_use; p++) begin
				if (!done[p]) begin
					fits = 1'b1;
					for (r = 0; r < res_in_use; r++)
						if (work_t'(ledger_need(p, r)) > work[r])
							fits = 1'b0;
					if (fits) begin
						for (r = 0; r < res_in_use; r++)
							work[r] += work_t'(ledger_alloc[p][r]);
						done[p] = 1'b1;
						moved = 1'b1;
					end
				end
			end
		end
		for (p = 0; p < procs_in_use; p++)
			if (!done[p])
				return 1'b0;
		return 1'b1;
	endfunction

	// safety, then need and available, then grant and check again
	function automatic status_t ledger_evaluate(input int unsigned p);
		int unsigned r;
		if (!ledger_safe())
			return ST_UNSAFE;
		if (p >= procs_in_use)
			return ST_REFUSED;
		for (r = 0; r < res_in_use; r++)
			if (ledger_req[r] > ledger_need(p, r) || ledger_req[r] > ledger_avail[r])
				return ST_REFUSED;
		// the grant stays in place whatever the second check says
		for (r = 0; r < res_in_use; r++) begin
			ledger_alloc[p][r] = ledger_alloc[p][r] + ledger_req[r];
			ledger_avail[r]    = ledger_avail[r] - ledger_req[r];
		end
		return ledger_safe() ? ST_GRANT_SAFE : ST_GRANT_UNSAFE;
	endfunction

	// apply one accepted word; returns 1 when it yields a status word
	function automatic bit ledger_apply(input item_t w, output status_t verdict,
	                                    output bit ignored);
		int unsigned p;
		int unsigned r;
		p       = 32'(w.process_index);
		r       = 32'(w.resource_index);
		verdict = ST_UNSAFE;
		ignored = 1'b0;
		if (w.op == OP_REQ) begin
			if (r < res_in_use)
				ledger_req[r] = w.value;
			else if (!w.last)
				ignored = 1'b1;
			if (!w.last)
				return 1'b0;
			verdict = ledger_evaluate(p);
			for (r = 0; r < MAX_RES; r++)
				ledger_req[r] = '0;
			return 1'b1;
		end
		// loads outside the rows and columns in use are dropped
		if (r >= res_in_use || (w.op != OP_AVAIL && p >= procs_in_use)) begin
			ignored = 1'b1;
			return 1'b0;
		end
		case (w.op)
			OP_AVAIL: ledger_avail[r] = w.value;
			OP_MAX:   ledger_max[p][r] = w.value;
			default:  ledger_alloc[p][r] = w.value;
		endcase
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("ERROR %0t: %s", $realtime, msg);
	endtask

	// sample both handshakes at the rising edge; outputs before inputs
	always @(posedge clk) begin : watch
		item_t   w;
		status_t want;
		status_t got;
		status_t guess;
		bit      ignored;
		if (arst_n === 1'b1) begin
			if (m_tvalid && m_tready) begin
				got = status_t'(m_tdata[1:0]);
				if (pending_status.size() == 0) begin
					note_failure($sformatf("status word %b with nothing expected", m_tdata[1:0]));
				end else begin
					want = pending_status.pop_front();
					if (got !== want)
						note_failure($sformatf("status mismatch: expected %s, got %b",
							want.name(), m_tdata[1:0]));
				end
				status_tally[m_tdata[1:0]]++;
			end
			if (s_tvalid && s_tready) begin
				w.op             = op_t'(s_tdata[1:0]);
				w.process_index  = s_tdata[5:2];
				w.resource_index = s_tdata[8:6];
				w.value          = s_tdata[24:9];
				w.last           = s_tlast;
				all_words++;
				if (ledger_apply(w, guess, ignored))
					pending_status.push_back(pinned_on ? pinned_status : guess);
				if (!ignored)
					taken_words++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic int pick_below(input int unsigned n);
		return (n == 0) ? 0 : $urandom_range(0, n - 1);
	endfunction

	// offer one word and hold it until taken, with an occasional gap before it
	task automatic push_word(input item_t w);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, w.value, w.resource_index, w.process_index, w.op};
		s_tlast  <= w.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait for every status word still owed
	task automatic settle_block(input int tail);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_status.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// APB register write, setup then access phase; only done while the engine is idle
	task automatic write_count(input cfg_reg_t idx, input cfg_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * int'(idx));
		pwdata  <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// counts above the built size saturate
		if (idx == REG_NUM_PROCS)
			procs_in_use = (32'(v) > MAX_PROCS) ? MAX_PROCS : 32'(v);
		else
			res_in_use = (32'(v) > MAX_RES) ? MAX_RES : 32'(v);
	endtask

	// available vector plus claim and allocation rows, mostly small counts
	task automatic reload_rows(input bit every_row);
		item_t       w;
		bit          huge;
		int unsigned p;
		int unsigned r;
		int unsigned top;
		huge   = ($urandom_range(0, 11) == 0);
		w.last = 1'b0;
		w.process_index = '0;
		for (r = 0; r < res_in_use; r++) begin
			w.op             = OP_AVAIL;
			w.resource_index = 3'(r);
			w.value          = huge ? unit_t'($urandom) : unit_t'($urandom_range(0, 15));
			push_word(w);
		end
		for (p = 0; p < procs_in_use; p++) begin
			if (every_row || p == 0) begin
				// a single-row refresh hits a random row
				w.process_index = every_row ? 4'(p) : 4'(pick_below(procs_in_use));
				for (r = 0; r < res_in_use; r++) begin
					w.resource_index = 3'(r);
					w.op             = OP_MAX;
					w.value          = huge ? unit_t'($urandom) : unit_t'($urandom_range(0, 10));
					top              = 32'(w.value);
					push_word(w);
					w.op = OP_ALLOC;
					// now and then allocate above the claim so the need clamps
					if (huge)
						w.value = unit_t'($urandom);
					else if ($urandom_range(0, 9) == 0)
						w.value = unit_t'(top + $urandom_range(1, 3));
					else
						w.value = unit_t'($urandom_range(0, top));
					push_word(w);
				end
			end
		end
	endtask

	// a few loads, then a request vector closed by tlast
	task automatic request_burst();
		item_t       w;
		int unsigned p;
		int unsigned r;
		int unsigned need;
		int unsigned room;
		int unsigned roll;
		repeat ($urandom_range(0, 3)) begin
			w.op             = op_t'($urandom_range(0, 2));
			w.process_index  = 4'(pick_below(procs_in_use));
			w.resource_index = 3'(pick_below(res_in_use));
			w.value          = unit_t'($urandom_range(0, 12));
			w.last           = 1'b0;
			push_word(w);
		end
		// mostly a valid process, sometimes any index
		p = ($urandom_range(0, 9) == 0 || procs_in_use == 0) ?
			$urandom_range(0, 15) : 32'(pick_below(procs_in_use));
		w.op            = OP_REQ;
		w.process_index = 4'(p);
		if (res_in_use == 0) begin
			w.resource_index = 3'($urandom_range(0, 7));
			w.value          = unit_t'($urandom);
			w.last           = 1'b1;
			push_word(w);
		end else begin
			for (r = 0; r < res_in_use; r++) begin
				w.last           = (r == res_in_use - 1);
				w.resource_index = 3'(r);
				// an element outside the columns in use may close the vector
				if (w.last && res_in_use < MAX_RES && $urandom_range(0, 9) == 0)
					w.resource_index = 3'($urandom_range(res_in_use, MAX_RES - 1));
				need = (p < procs_in_use) ? 32'(ledger_need(p, r)) : 32'd4;
				room = 32'(ledger_avail[r]);
				roll = $urandom_range(0, 9);
				if (roll < 7)
					w.value = unit_t'($urandom_range(0, (need < room) ? need : room));
				else if (roll < 9)
					w.value = unit_t'($urandom_range(0, need + 2));
				else
					w.value = unit_t'($urandom);
				// skipped elements keep their value in the request vector, zero unless set since the last evaluation
				if (w.last || $urandom_range(0, 3) != 0)
					push_word(w);
			end
		end
	endtask

	task automatic run_episode();
		item_t       w;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			reload_rows(1'b0);
		end else if (pick < 68) begin
			request_burst();
		end else if (pick < 96) begin
			// noise: any op, any index, any value, tlast anywhere
			repeat ($urandom_range(1, 4)) begin
				w.op             = op_t'($urandom_range(0, 3));
				w.process_index  = 4'($urandom_range(0, 15));
				w.resource_index = 3'($urandom_range(0, 7));
				w.value          = unit_t'($urandom);
				w.last           = 1'($urandom_range(0, 1));
				push_word(w);
			end
		end else begin
			// hold off until the engine has drained
			settle_block(0);
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin : stimulus
		int start;
		int k;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		for (k = 0; k < MAX_RES; k++) begin
			ledger_avail[k] = '0;
			ledger_req[k]   = '0;
		end
		for (k = 0; k < MAX_PROCS * MAX_RES; k++) begin
			ledger_max[k / MAX_RES][k % MAX_RES]   = '0;
			ledger_alloc[k / MAX_RES][k % MAX_RES] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows at the reset counts
		foreach (probe_rows[i]) begin
			pinned_on     = probe_rows[i].pinned;
			pinned_status = probe_rows[i].want;
			push_word(probe_rows[i].w);
		end
		pinned_on = 1'b0;

		// random phases, each at its own register setting
		for (k = 0; k < $size(phase_plan); k++) begin
			settle_block(16);
			calm = (k == $size(phase_plan) - 1);
			write_count(REG_NUM_PROCS, phase_plan[k].procs);
			write_count(REG_NUM_RES, phase_plan[k].res);
			settings_seen++;
			start = taken_words;
			reload_rows(1'b1);
			while (taken_words - start < phase_plan[k].words)
				run_episode();
		end
		settle_block(64);

		$display("covered %0d words (%0d effective) over %0d register settings",
			all_words, taken_words, settings_seen);
		$display("status words: unsafe %0d, refused %0d, granted safe %0d, granted unsafe %0d",
			status_tally[ST_UNSAFE], status_tally[ST_REFUSED],
			status_tally[ST_GRANT_SAFE], status_tally[ST_GRANT_UNSAFE]);
		if (failures == 0) begin
			$display("bankers_request_safety_check regression: pass");
		end else begin
			$display("%0d failures", failures);
			$display("bankers_request_safety_check regression: fail");
		end
		$finish;
	end

	// result side: ready with random stall bursts, steady in the calm phase
	initial begin : sink
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	end

	// worst case: every word a full 8x8 evaluation with two safety walks plus
	// the longest gap and stall, taken several times over
	initial begin : watchdog
		#400_000_000;
		$display("timeout with %0d status words outstanding", pending_status.size());
		$display("bankers_request_safety_check regression: fail");
		$finish;
	end

endmodule
